// File: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants of the sprite stream zero-run decoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam logic [7:0]  MAGIC_S = 8'h53;
	localparam logic [7:0]  MAGIC_P = 8'h50;
	localparam logic [15:0] VER_1_0 = 16'h0100;
	localparam logic [15:0] VER_1_1 = 16'h0101;
	localparam logic [15:0] VER_2_0 = 16'h0200;
	localparam logic [15:0] VER_2_1 = 16'h0201;

	typedef enum logic [4:0] {
		PH_MAG0  = 5'd0,
		PH_MAG1  = 5'd1,
		PH_VER0  = 5'd2,
		PH_VER1  = 5'd3,
		PH_PC0   = 5'd4,
		PH_PC1   = 5'd5,
		PH_RC0   = 5'd6,
		PH_RC1   = 5'd7,
		PH_PW0   = 5'd8,
		PH_PW1   = 5'd9,
		PH_PH0   = 5'd10,
		PH_PH1   = 5'd11,
		PH_RW0   = 5'd12,
		PH_RW1   = 5'd13,
		PH_RH0   = 5'd14,
		PH_RH1   = 5'd15,
		PH_ENC0  = 5'd16,
		PH_ENC1  = 5'd17,
		PH_RAW   = 5'd18,
		PH_COL   = 5'd19,
		PH_LEN   = 5'd20,
		PH_RGBA  = 5'd21,
		PH_DONE  = 5'd22,
		PH_HALT  = 5'd23
	} phase_t;

	typedef enum logic [2:0] {
		K_PSTART = 3'd0,
		K_RSTART = 3'd1,
		K_RUN    = 3'd2,
		K_PIX    = 3'd3,
		K_DONE   = 3'd4,
		K_ERR    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ERR_MAGIC   = 2'd0,
		ERR_VERSION = 2'd1,
		ERR_RUN     = 2'd2,
		ERR_SHORT   = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
		logic       new_file;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] image_number;
		logic [7:0]  color_index;
		logic [7:0]  run_length;
		logic [31:0] rgba_value;
		logic        ends_image;
		logic [31:0] unfilled_pixels;
		logic        ends_file;
		err_t        error_code;
	} result_t;

endpackage

// File: rtl/ssd_parse.sv
// ----------------------------------------------------------------------------
// ssd_parse
// Parser state and the single-byte update: takes one registered byte and
// gives the next state plus at most one result.
// ----------------------------------------------------------------------------
module ssd_parse import ssd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output logic     have_res,
	output result_t  res
);

	phase_t      ph_q;
	logic        magic_ok_q;
	logic [1:0]  bpos_q;
	logic [15:0] ver_q, ptot_q, rtot_q, cnt_q, wid_q, hgt_q, enc_q;
	logic [31:0] pix_q;
	logic [23:0] part_q;

	phase_t      c_ph, n_ph;
	logic        c_magic_ok, n_magic_ok;
	logic [1:0]  c_bpos, n_bpos;
	logic [15:0] c_ver, c_ptot, c_rtot, c_cnt, c_wid, c_hgt, c_enc;
	logic [15:0] n_ver, n_ptot, n_rtot, n_cnt, n_wid, n_hgt, n_enc;
	logic [31:0] c_pix, n_pix;
	logic [23:0] c_part, n_part;

	// a new file starts from the reset state
	always_comb begin
		if (item.new_file) begin
			c_ph       = PH_MAG0;
			c_magic_ok = 1'b0;
			c_bpos     = '0;
			c_ver      = '0;
			c_ptot     = '0;
			c_rtot     = '0;
			c_cnt      = '0;
			c_wid      = '0;
			c_hgt      = '0;
			c_enc      = '0;
			c_pix      = '0;
			c_part     = '0;
		end else begin
			c_ph       = ph_q;
			c_magic_ok = magic_ok_q;
			c_bpos     = bpos_q;
			c_ver      = ver_q;
			c_ptot     = ptot_q;
			c_rtot     = rtot_q;
			c_cnt      = cnt_q;
			c_wid      = wid_q;
			c_hgt      = hgt_q;
			c_enc      = enc_q;
			c_pix      = pix_q;
			c_part     = part_q;
		end
	end

	// move to the next image of a group, or on to the rgba group or the file end
	logic [15:0] cnt_inc;
	phase_t      pal_ph, rgb_ph;
	logic [15:0] pal_cnt, rgb_cnt;
	logic        pal_done, rgb_done;

	assign cnt_inc = c_cnt + 16'd1;

	always_comb begin
		priority if (cnt_inc < c_ptot) begin
			pal_ph   = PH_PW0;
			pal_cnt  = cnt_inc;
			pal_done = 1'b0;
		end else if (c_rtot != '0) begin
			pal_ph   = PH_RW0;
			pal_cnt  = '0;
			pal_done = 1'b0;
		end else begin
			pal_ph   = PH_DONE;
			pal_cnt  = '0;
			pal_done = 1'b1;
		end
		rgb_done = !(cnt_inc < c_rtot);
		rgb_ph   = rgb_done ? PH_DONE : PH_RW0;
		rgb_cnt  = cnt_inc;
	end

	logic [7:0]  b;
	logic [7:0]  run_len;
	logic        err_now;
	logic        is_rgba;
	logic [15:0] ver_new;

	assign b       = item.in_byte;
	assign run_len = (b == '0) ? 8'd1 : b;
	assign ver_new = {b, c_ver[7:0]};
	assign is_rgba = (c_ph == PH_RH1);

	always_comb begin
		n_ph       = c_ph;
		n_magic_ok = c_magic_ok;
		n_bpos     = c_bpos;
		n_ver      = c_ver;
		n_ptot     = c_ptot;
		n_rtot     = c_rtot;
		n_cnt      = c_cnt;
		n_wid      = c_wid;
		n_hgt      = c_hgt;
		n_enc      = c_enc;
		n_pix      = c_pix;
		n_part     = c_part;
		have_res   = 1'b0;
		err_now    = 1'b0;
		res        = '0;

		unique case (c_ph)
			PH_MAG0: begin
				n_magic_ok = (b == MAGIC_S);
				n_ph       = PH_MAG1;
			end
			PH_MAG1: begin
				n_bpos = '0;
				if (!c_magic_ok || b != MAGIC_P) begin
					have_res       = 1'b1;
					res.kind       = K_ERR;
					res.error_code = ERR_MAGIC;
					n_ph           = PH_HALT;
					err_now        = 1'b1;
				end else begin
					n_ph = PH_VER0;
				end
			end
			PH_VER0: begin
				n_ver = {8'd0, b};
				n_ph  = PH_VER1;
			end
			PH_VER1: begin
				n_ver = ver_new;
				if (ver_new == VER_1_0 || ver_new == VER_1_1 ||
				    ver_new == VER_2_0 || ver_new == VER_2_1) begin
					n_ph = PH_PC0;
				end else begin
					have_res       = 1'b1;
					res.kind       = K_ERR;
					res.error_code = ERR_VERSION;
					n_ph           = PH_HALT;
					err_now        = 1'b1;
				end
			end
			PH_PC0: begin
				n_ptot = {8'd0, b};
				n_ph   = PH_PC1;
			end
			PH_RC0: begin
				n_rtot = {8'd0, b};
				n_ph   = PH_RC1;
			end
			PH_PC1, PH_RC1: begin
				if (c_ph == PH_PC1) begin
					n_ptot = {b, c_ptot[7:0]};
				end else begin
					n_rtot = {b, c_rtot[7:0]};
				end
				if (c_ph == PH_PC1 && c_ver >= VER_2_0) begin
					n_ph = PH_RC0;
				end else begin
					if (c_ph == PH_PC1) begin
						n_rtot = '0;
					end
					// enter the palette group, the rgba group if it is empty, or done if both are empty
					n_cnt = '0;
					priority if (n_ptot != '0) begin
						n_ph = PH_PW0;
					end else if (n_rtot != '0) begin
						n_ph = PH_RW0;
					end else begin
						n_ph          = PH_DONE;
						have_res      = 1'b1;
						res.kind      = K_DONE;
						res.ends_file = 1'b1;
					end
				end
			end
			PH_PW0, PH_RW0: begin
				n_wid = {8'd0, b};
				n_ph  = phase_t'(c_ph + 5'd1);
			end
			PH_PW1, PH_RW1: begin
				n_wid = {b, c_wid[7:0]};
				n_ph  = phase_t'(c_ph + 5'd1);
			end
			PH_PH0, PH_RH0: begin
				n_hgt = {8'd0, b};
				n_ph  = phase_t'(c_ph + 5'd1);
			end
			PH_PH1, PH_RH1: begin
				n_hgt = {b, c_hgt[7:0]};
				n_pix = {16'd0, n_wid} * {16'd0, n_hgt};
				priority if (n_wid == '0 || n_hgt == '0) begin
					// empty image: skipped, its number is used up
					n_ph  = is_rgba ? rgb_ph : pal_ph;
					n_cnt = is_rgba ? rgb_cnt : pal_cnt;
					if (is_rgba ? rgb_done : pal_done) begin
						have_res      = 1'b1;
						res.kind      = K_DONE;
						res.ends_file = 1'b1;
					end
				end else if (is_rgba) begin
					have_res         = 1'b1;
					res.kind         = K_RSTART;
					res.image_width  = n_wid;
					res.image_height = n_hgt;
					res.image_number = n_cnt;
					n_bpos           = '0;
					n_ph             = PH_RGBA;
				end else if (c_ver >= VER_2_1) begin
					n_ph = PH_ENC0;
				end else begin
					have_res         = 1'b1;
					res.kind         = K_PSTART;
					res.image_width  = n_wid;
					res.image_height = n_hgt;
					res.image_number = n_cnt;
					n_ph             = PH_RAW;
				end
			end
			PH_ENC0: begin
				n_enc = {8'd0, b};
				n_ph  = PH_ENC1;
			end
			PH_ENC1: begin
				n_enc            = {b, c_enc[7:0]};
				have_res         = 1'b1;
				res.kind         = K_PSTART;
				res.image_width  = n_wid;
				res.image_height = n_hgt;
				res.image_number = n_cnt;
				if (n_enc == '0) begin
					res.ends_image      = 1'b1;
					res.unfilled_pixels = n_pix;
					res.ends_file       = pal_done;
					n_ph                = pal_ph;
					n_cnt               = pal_cnt;
				end else begin
					n_ph = PH_COL;
				end
			end
			PH_RAW: begin
				have_res         = 1'b1;
				res.kind         = K_RUN;
				res.image_width  = n_wid;
				res.image_height = n_hgt;
				res.image_number = n_cnt;
				res.color_index  = b;
				res.run_length   = 8'd1;
				n_pix            = c_pix - 32'd1;
				if (n_pix == '0) begin
					res.ends_image      = 1'b1;
					res.unfilled_pixels = n_pix;
					res.ends_file       = pal_done;
					n_ph                = pal_ph;
					n_cnt               = pal_cnt;
				end
			end
			PH_COL: begin
				n_enc = c_enc - 16'd1;
				if (b == '0) begin
					n_ph = PH_LEN;
				end else begin
					have_res         = 1'b1;
					res.kind         = K_RUN;
					res.image_width  = n_wid;
					res.image_height = n_hgt;
					res.image_number = n_cnt;
					res.color_index  = b;
					res.run_length   = 8'd1;
					n_pix            = c_pix - 32'd1;
					if (n_pix == '0 || n_enc == '0) begin
						res.ends_image      = 1'b1;
						res.unfilled_pixels = n_pix;
						res.ends_file       = pal_done;
						n_ph                = pal_ph;
						n_cnt               = pal_cnt;
					end
				end
			end
			PH_LEN: begin
				// the encoded count holds at zero when the marker was the last encoded byte
				if (c_enc != '0) begin
					n_enc = c_enc - 16'd1;
				end
				if ({24'd0, run_len} > c_pix) begin
					have_res       = 1'b1;
					res.kind       = K_ERR;
					res.error_code = ERR_RUN;
					n_ph           = PH_HALT;
					err_now        = 1'b1;
				end else begin
					have_res         = 1'b1;
					res.kind         = K_RUN;
					res.image_width  = n_wid;
					res.image_height = n_hgt;
					res.image_number = n_cnt;
					res.run_length   = run_len;
					n_pix            = c_pix - {24'd0, run_len};
					if (n_pix == '0 || n_enc == '0) begin
						res.ends_image      = 1'b1;
						res.unfilled_pixels = n_pix;
						res.ends_file       = pal_done;
						n_ph                = pal_ph;
						n_cnt               = pal_cnt;
					end else begin
						n_ph = PH_COL;
					end
				end
			end
			PH_RGBA: begin
				if (c_bpos != 2'd3) begin
					n_part = {c_part[15:0], b};
					n_bpos = c_bpos + 2'd1;
				end else begin
					have_res         = 1'b1;
					res.kind         = K_PIX;
					res.image_width  = n_wid;
					res.image_height = n_hgt;
					res.image_number = n_cnt;
					res.rgba_value   = {c_part, b};
					n_bpos           = '0;
					n_part           = '0;
					n_pix            = c_pix - 32'd1;
					if (n_pix == '0) begin
						res.ends_image      = 1'b1;
						res.unfilled_pixels = n_pix;
						res.ends_file       = rgb_done;
						n_ph                = rgb_ph;
						n_cnt               = rgb_cnt;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
				n_ph = PH_HALT;
			end
		endcase

		// file ended before its structure was complete
		if (item.last_byte && !err_now && n_ph != PH_DONE && n_ph != PH_HALT) begin
			have_res       = 1'b1;
			res            = '0;
			res.kind       = K_ERR;
			res.error_code = ERR_SHORT;
			n_ph           = PH_HALT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_MAG0;
			magic_ok_q <= 1'b0;
			bpos_q     <= '0;
			ver_q      <= '0;
			ptot_q     <= '0;
			rtot_q     <= '0;
			cnt_q      <= '0;
			wid_q      <= '0;
			hgt_q      <= '0;
			enc_q      <= '0;
			pix_q      <= '0;
			part_q     <= '0;
		end else if (step) begin
			ph_q       <= n_ph;
			magic_ok_q <= n_magic_ok;
			bpos_q     <= n_bpos;
			ver_q      <= n_ver;
			ptot_q     <= n_ptot;
			rtot_q     <= n_rtot;
			cnt_q      <= n_cnt;
			wid_q      <= n_wid;
			hgt_q      <= n_hgt;
			enc_q      <= n_enc;
			pix_q      <= n_pix;
			part_q     <= n_part;
		end
	end

endmodule

// File: rtl/sprite_stream_zero_run_decoder.sv
// a byte is held in the input register and its result then goes into the result register
// throughput: one byte per cycle while the result register is not stalled, set by the
// single parser update between the input register and the result register
// reset: arst_n clears the parser to await the first magic byte and empties both registers
// ----------------------------------------------------------------------------
// sprite_stream_zero_run_decoder
// Byte-stream sprite file parser with zero-run palette decoding.
// ----------------------------------------------------------------------------
module sprite_stream_zero_run_decoder import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	input  logic        new_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [15:0] image_number,
	output logic [7:0]  color_index,
	output logic [7:0]  run_length,
	output logic [31:0] rgba_value,
	output logic        ends_image,
	output logic [31:0] unfilled_pixels,
	output logic        ends_file,
	output logic [1:0]  error_code
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     out_valid_q;
	result_t  res_q;

	logic     advance;
	logic     step;
	logic     have_res;
	result_t  res;

	// the result register frees up when empty or being taken
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= step && have_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{in_byte: in_byte, last_byte: last_byte, new_file: new_file};
		end
		if (step) begin
			res_q <= res;
		end
	end

	ssd_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.have_res (have_res),
		.res      (res)
	);

	assign out_valid       = out_valid_q;
	assign kind            = res_q.kind;
	assign image_width     = res_q.image_width;
	assign image_height    = res_q.image_height;
	assign image_number    = res_q.image_number;
	assign color_index     = res_q.color_index;
	assign run_length      = res_q.run_length;
	assign rgba_value      = res_q.rgba_value;
	assign ends_image      = res_q.ends_image;
	assign unfilled_pixels = res_q.unfilled_pixels;
	assign ends_file       = res_q.ends_file;
	assign error_code      = res_q.error_code;

`ifndef SYNTHESIS
	a_run_fields_only_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != K_RUN |-> run_length == 8'd0 && color_index == 8'd0)
		else $error("run fields set on a non-run result");

	a_run_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_RUN |-> run_length != 8'd0)
		else $error("palette run with zero length");

	a_error_ends_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_ERR |-> !ends_image && !ends_file)
		else $error("error result marks an image or file end");

	a_file_end_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ends_file |-> ends_image || kind == K_DONE)
		else $error("file end without image end or done");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the sprite stream zero-run decoder byte by byte: a short scripted
// stream first, then random sprite files, mostly well formed, some damaged,
// with stray bytes between them. Every decoder event is predicted here and
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
	import ssd_pkg::*;

	localparam int RANDOM_BYTES = 600;
	localparam int STALL_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       nf;
		logic       typed;
		result_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        new_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [15:0] image_number;
	logic [7:0]  color_index;
	logic [7:0]  run_length;
	logic [31:0] rgba_value;
	logic        ends_image;
	logic [31:0] unfilled_pixels;
	logic        ends_file;
	logic [1:0]  error_code;

	// parser copy
	phase_t      stage;
	logic [7:0]  hold_byte;
	logic [15:0] ver;
	logic [15:0] pal_total;
	logic [15:0] rgb_total;
	logic [15:0] img_idx;
	logic [15:0] w_hold;
	logic [15:0] h_hold;
	logic [31:0] px_left;
	logic [15:0] enc_left;
	logic [23:0] rgb_acc;
	result_t     pred;
	logic        pred_hit;

	result_t     awaited_events[$];
	row_t        script[$];
	logic [7:0]  file_bytes[$];
	int          bytes_sent = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          src_idle_pct = 21;
	int          sink_idle_pct = 21;

	sprite_stream_zero_run_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.last_byte(last_byte),
		.new_file(new_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.image_width(image_width),
		.image_height(image_height),
		.image_number(image_number),
		.color_index(color_index),
		.run_length(run_length),
		.rgba_value(rgba_value),
		.ends_image(ends_image),
		.unfilled_pixels(unfilled_pixels),
		.ends_file(ends_file),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	function automatic void clear_parser();
		stage = PH_MAG0;
		hold_byte = 8'd0;
		ver = 16'd0;
		pal_total = 16'd0;
		rgb_total = 16'd0;
		img_idx = 16'd0;
		w_hold = 16'd0;
		h_hold = 16'd0;
		px_left = 32'd0;
		enc_left = 16'd0;
		rgb_acc = 24'd0;
	endfunction

	function automatic void announce(kind_t k);
		pred = '0;
		pred.kind = k;
		if (k <= K_PIX) begin
			pred.image_width = w_hold;
			pred.image_height = h_hold;
			pred.image_number = img_idx;
		end
		pred_hit = 1'b1;
	endfunction

	function automatic void raise_fault(err_t code);
		announce(K_ERR);
		pred.error_code = code;
		stage = PH_HALT;
	endfunction

	function automatic logic enter_rgba();
		img_idx = 16'd0;
		if (rgb_total != 16'd0) begin
			stage = PH_RW0;
			return 1'b0;
		end
		stage = PH_DONE;
		return 1'b1;
	endfunction

	function automatic logic enter_palette();
		img_idx = 16'd0;
		if (pal_total != 16'd0) begin
			stage = PH_PW0;
			return 1'b0;
		end
		return enter_rgba();
	endfunction

	// returns 1 when the whole file is complete
	function automatic logic next_image(logic rgba_img);
		img_idx = img_idx + 16'd1;
		if (!rgba_img) begin
			if (img_idx < pal_total) begin
				stage = PH_PW0;
				return 1'b0;
			end
			return enter_rgba();
		end
		if (img_idx < rgb_total) begin
			stage = PH_RW0;
			return 1'b0;
		end
		stage = PH_DONE;
		return 1'b1;
	endfunction

	function automatic void close_image(logic rgba_img);
		pred.ends_image = 1'b1;
		pred.unfilled_pixels = px_left;
		if (next_image(rgba_img))
			pred.ends_file = 1'b1;
	endfunction

	// a file that completes without an event of its own gets a done event
	function automatic void finish_if_complete(logic complete);
		if (complete) begin
			announce(K_DONE);
			pred.ends_file = 1'b1;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic l, logic nf);
		logic [7:0] len;
		logic       rgba_img;
		if (nf)
			clear_parser();
		pred_hit = 1'b0;
		case (stage)
			PH_MAG0: begin
				hold_byte = b;
				stage = PH_MAG1;
			end
			PH_MAG1: begin
				if (hold_byte != MAGIC_S || b != MAGIC_P)
					raise_fault(ERR_MAGIC);
				else
					stage = PH_VER0;
				hold_byte = 8'd0;
			end
			PH_VER0: begin
				ver = {8'd0, b};
				stage = PH_VER1;
			end
			PH_VER1: begin
				ver[15:8] = b;
				if (ver == VER_1_0 || ver == VER_1_1 || ver == VER_2_0 || ver == VER_2_1)
					stage = PH_PC0;
				else
					raise_fault(ERR_VERSION);
			end
			PH_PC0: begin
				pal_total = {8'd0, b};
				stage = PH_PC1;
			end
			PH_PC1: begin
				pal_total[15:8] = b;
				if (ver >= VER_2_0) begin
					stage = PH_RC0;
				end else begin
					rgb_total = 16'd0;
					finish_if_complete(enter_palette());
				end
			end
			PH_RC0: begin
				rgb_total = {8'd0, b};
				stage = PH_RC1;
			end
			PH_RC1: begin
				rgb_total[15:8] = b;
				finish_if_complete(enter_palette());
			end
			PH_PW0, PH_RW0: begin
				w_hold = {8'd0, b};
				stage = phase_t'(stage + 5'd1);
			end
			PH_PW1, PH_RW1: begin
				w_hold[15:8] = b;
				stage = phase_t'(stage + 5'd1);
			end
			PH_PH0, PH_RH0: begin
				h_hold = {8'd0, b};
				stage = phase_t'(stage + 5'd1);
			end
			PH_PH1, PH_RH1: begin
				rgba_img = (stage == PH_RH1);
				h_hold[15:8] = b;
				px_left = {16'd0, w_hold} * {16'd0, h_hold};
				if (px_left == 32'd0) begin
					finish_if_complete(next_image(rgba_img));
				end else if (rgba_img) begin
					announce(K_RSTART);
					hold_byte = 8'd0;
					stage = PH_RGBA;
				end else if (ver >= VER_2_1) begin
					stage = PH_ENC0;
				end else begin
					announce(K_PSTART);
					stage = PH_RAW;
				end
			end
			PH_ENC0: begin
				enc_left = {8'd0, b};
				stage = PH_ENC1;
			end
			PH_ENC1: begin
				enc_left[15:8] = b;
				announce(K_PSTART);
				if (enc_left == 16'd0)
					close_image(1'b0);
				else
					stage = PH_COL;
			end
			PH_RAW: begin
				announce(K_RUN);
				pred.color_index = b;
				pred.run_length = 8'd1;
				px_left = px_left - 32'd1;
				if (px_left == 32'd0)
					close_image(1'b0);
			end
			PH_COL: begin
				enc_left = enc_left - 16'd1;
				if (b == 8'd0) begin
					stage = PH_LEN;
				end else begin
					announce(K_RUN);
					pred.color_index = b;
					pred.run_length = 8'd1;
					px_left = px_left - 32'd1;
					if (px_left == 32'd0 || enc_left == 16'd0)
						close_image(1'b0);
				end
			end
			PH_LEN: begin
				// the count holds at zero when the marker was the last encoded byte
				if (enc_left != 16'd0)
					enc_left = enc_left - 16'd1;
				len = (b != 8'd0) ? b : 8'd1;
				if ({24'd0, len} > px_left) begin
					raise_fault(ERR_RUN);
				end else begin
					announce(K_RUN);
					pred.run_length = len;
					px_left = px_left - {24'd0, len};
					if (px_left == 32'd0 || enc_left == 16'd0)
						close_image(1'b0);
					else
						stage = PH_COL;
				end
			end
			PH_RGBA: begin
				if (hold_byte < 8'd3) begin
					rgb_acc = {rgb_acc[15:0], b};
					hold_byte = hold_byte + 8'd1;
				end else begin
					announce(K_PIX);
					pred.rgba_value = {rgb_acc, b};
					hold_byte = 8'd0;
					rgb_acc = 24'd0;
					px_left = px_left - 32'd1;
					if (px_left == 32'd0)
						close_image(1'b1);
				end
			end
			PH_DONE: ;
			default: stage = PH_HALT;
		endcase
		if (l && stage != PH_DONE && stage != PH_HALT)
			raise_fault(ERR_SHORT);
	endfunction

	function automatic result_t fault_event(err_t code);
		result_t r;
		r = '0;
		r.kind = K_ERR;
		r.error_code = code;
		return r;
	endfunction

	function automatic void add_row(logic [7:0] b, logic l, logic nf, logic typed, result_t want);
		row_t r;
		r.b = b;
		r.l = l;
		r.nf = nf;
		r.typed = typed;
		r.want = want;
		script.push_back(r);
	endfunction

	// random sprite file: mostly small images, now and then an empty one with wide fields
	function automatic void compose_file();
		logic [15:0] fver;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] tmp;
		int          npal;
		int          nrgb;
		int          px;
		int          left;
		int          len;
		int          elen;
		int          nsend;
		logic [7:0]  enc[$];
		bit          zmark[$];
		file_bytes.delete();
		case ($urandom_range(3))
			0: fver = VER_1_0;
			1: fver = VER_1_1;
			2: fver = VER_2_0;
			default: fver = VER_2_1;
		endcase
		file_bytes.push_back(MAGIC_S);
		file_bytes.push_back(MAGIC_P);
		file_bytes.push_back(fver[7:0]);
		file_bytes.push_back(fver[15:8]);
		npal = $urandom_range(3);
		file_bytes.push_back(npal[7:0]);
		file_bytes.push_back(8'd0);
		nrgb = 0;
		if (fver >= VER_2_0) begin
			nrgb = $urandom_range(2);
			file_bytes.push_back(nrgb[7:0]);
			file_bytes.push_back(8'd0);
		end
		for (int g = 0; g < npal + nrgb; g++) begin
			if ($urandom_range(7) == 0) begin
				w = 16'($urandom);
				h = 16'd0;
				if ($urandom_range(1)) begin
					tmp = w;
					w = h;
					h = tmp;
				end
			end else begin
				w = 16'($urandom_range(1, 4));
				h = 16'($urandom_range(1, 3));
			end
			file_bytes.push_back(w[7:0]);
			file_bytes.push_back(w[15:8]);
			file_bytes.push_back(h[7:0]);
			file_bytes.push_back(h[15:8]);
			px = w * h;
			if (px == 0)
				continue;
			if (g >= npal) begin
				repeat (4 * px) file_bytes.push_back(8'($urandom));
			end else if (fver != VER_2_1) begin
				repeat (px) file_bytes.push_back(8'($urandom));
			end else begin
				enc.delete();
				zmark.delete();
				left = px;
				while (left > 0) begin
					if ($urandom_range(2) == 0) begin
						len = $urandom_range(1, left);
						if ($urandom_range(15) == 0)
							len = left + 1 + $urandom_range(254 - left);
						enc.push_back(8'd0);
						zmark.push_back(1'b1);
						// a stored zero also means one pixel
						if (len == 1 && $urandom_range(1))
							enc.push_back(8'd0);
						else
							enc.push_back(len[7:0]);
						zmark.push_back(1'b0);
						left = left - len;
					end else begin
						enc.push_back(8'($urandom_range(1, 255)));
						zmark.push_back(1'b0);
						left = left - 1;
					end
				end
				elen = enc.size();
				nsend = elen;
				case ($urandom_range(5))
					0: begin
						// short encoded length; a trailing marker still pulls its length byte
						elen = $urandom_range(enc.size() - 1);
						nsend = elen;
						if (elen > 0 && zmark[elen - 1])
							nsend = elen + 1;
					end
					1: elen = elen + $urandom_range(1, 300);
					default: ;
				endcase
				file_bytes.push_back(elen[7:0]);
				file_bytes.push_back(elen[15:8]);
				for (int i = 0; i < nsend; i++)
					file_bytes.push_back(enc[i]);
			end
		end
		// trailing stray bytes
		if ($urandom_range(1))
			repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, input logic nf,
			input logic typed, input result_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= l;
		new_file <= nf;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		decode_byte(b, l, nf);
		if (typed)
			awaited_events.push_back(want);
		else if (pred_hit)
			awaited_events.push_back(pred);
	endtask

	task automatic drain_events();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_events.size() != 0);
	endtask

	task automatic send_file();
		int         stop;
		int         idx;
		int         mode;
		logic       open_end;
		logic [7:0] flip;
		compose_file();
		stop = file_bytes.size() - 1;
		open_end = 1'b0;
		mode = $urandom_range(9);
		if (mode == 0) begin
			idx = $urandom_range(stop);
			flip = 8'($urandom_range(1, 255));
			file_bytes[idx] = file_bytes[idx] ^ flip;
		end else if (mode == 1) begin
			stop = $urandom_range(stop);
		end else if (mode == 2) begin
			// abandoned file, the next one restarts the parser
			stop = $urandom_range(stop);
			open_end = 1'b1;
		end
		for (int i = 0; i <= stop; i++)
			send_byte(file_bytes[i], (i == stop) && !open_end, i == 0, 1'b0, '0);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin : event_monitor
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual kind %0d",
					$time, kind);
				mismatches++;
			end else begin
				want = awaited_events.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("image_width", 32'(want.image_width), 32'(image_width));
				check_field("image_height", 32'(want.image_height), 32'(image_height));
				check_field("image_number", 32'(want.image_number), 32'(image_number));
				check_field("color_index", 32'(want.color_index), 32'(color_index));
				check_field("run_length", 32'(want.run_length), 32'(run_length));
				check_field("rgba_value", want.rgba_value, rgba_value);
				check_field("ends_image", 32'(want.ends_image), 32'(ends_image));
				check_field("unfilled_pixels", want.unfilled_pixels, unfilled_pixels);
				check_field("ends_file", 32'(want.ends_file), 32'(ends_file));
				check_field("error_code", 32'(want.error_code), 32'(error_code));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		result_t done_evt;
		int      directed_bytes;
		logic    drained;
		int      nnoise;
		clear_parser();
		done_evt = '0;
		done_evt.kind = K_DONE;
		done_evt.ends_file = 1'b1;

		// bad magic, then a byte that the halted parser ignores
		add_row(8'h58, 1'b0, 1'b1, 1'b0, '0);
		add_row(MAGIC_P, 1'b0, 1'b0, 1'b1, fault_event(ERR_MAGIC));
		add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
		// unknown version
		add_row(MAGIC_S, 1'b0, 1'b1, 1'b0, '0);
		add_row(MAGIC_P, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h03, 1'b0, 1'b0, 1'b1, fault_event(ERR_VERSION));
		// version 2.1: one palette image, two rgba images, the second empty
		add_row(MAGIC_S, 1'b0, 1'b1, 1'b0, '0);
		add_row(MAGIC_P, 1'b0, 1'b0, 1'b0, '0);
		add_row(VER_2_1[7:0], 1'b0, 1'b0, 1'b0, '0);
		add_row(VER_2_1[15:8], 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h02, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h02, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h03, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h02, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b1, 1'b0, 1'b1, done_evt);
		// trailing stray byte after done
		add_row(8'h5A, 1'b1, 1'b0, 1'b0, '0);
		// file cut after its magic
		add_row(MAGIC_S, 1'b0, 1'b1, 1'b0, '0);
		add_row(MAGIC_P, 1'b1, 1'b0, 1'b1, fault_event(ERR_SHORT));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_byte(script[i].b, script[i].l, script[i].nf, script[i].typed, script[i].want);
		drain_events();

		directed_bytes = bytes_sent;
		drained = 1'b0;
		while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
			// a long stretch where neither side holds back
			if (bytes_sent >= directed_bytes + 300 && bytes_sent < directed_bytes + 420) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				src_idle_pct = 21;
				sink_idle_pct = 21;
			end
			if (!drained && bytes_sent >= directed_bytes + 200) begin
				drain_events();
				drained = 1'b1;
			end
			if ($urandom_range(9) == 0) begin
				nnoise = $urandom_range(1, 6);
				for (int i = 0; i < nnoise; i++)
					send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(3) == 0,
						1'b0, '0);
			end else begin
				send_file();
			end
		end

		drain_events();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
